[design/ccm_pkg.sv]
package ccm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int WIN_D       = PATTERN_MAX - 1;
    localparam int ADDR_W      = $clog2(PATTERN_MAX);
    localparam int IDX_W       = $clog2(PATTERN_MAX + 1);
    localparam int FILL_W      = $clog2(WIN_D + 1);
    localparam int LEN_W       = 6;
    localparam int CP_W        = 21;
    localparam int TAG_W       = 16;

    localparam logic [TAG_W-1:0] TAG_MAX = '1;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_CELL = 2'd1,
        KIND_EOL  = 2'd2,
        KIND_PAGE = 2'd3
    } kind_t;

    typedef enum logic {
        RES_TAG   = 1'b0,
        RES_TOTAL = 1'b1
    } res_kind_t;

    // control shared by every window cell in one cycle
    typedef struct packed {
        logic             push;
        logic [IDX_W-1:0] fill_old;
        logic             tag_en;
        logic [IDX_W-1:0] tag_lo;
        logic [TAG_W-1:0] tag_val;
        logic             shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic load;
        logic cell_in;
        logic clear_index;
        logic clear_count;
    } match_req_t;

    typedef struct packed {
        logic             full_match;
        logic [TAG_W-1:0] tag_value;
        logic [TAG_W-1:0] count;
    } match_resp_t;

    function automatic logic [CP_W-1:0] fold_case(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] r;
        r = c;
        if (c >= CP_W'(8'h41) && c <= CP_W'(8'h5A))
            r = c + CP_W'(8'h20);
        return r;
    endfunction

endpackage

[design/ccm_cell.sv]
module ccm_cell (
    input  logic                          clk,
    input  logic [ccm_pkg::IDX_W-1:0]     pos,
    input  ccm_pkg::cell_ctrl_t           ctrl,
    input  logic [ccm_pkg::TAG_W-1:0]     next_ext,
    output logic [ccm_pkg::TAG_W-1:0]     ext
);

    logic [ccm_pkg::TAG_W-1:0] val_reg;
    logic [ccm_pkg::TAG_W-1:0] val_next;
    logic [ccm_pkg::TAG_W-1:0] base;

    always_comb
    begin
        // the newly pushed cell lands here untagged
        base = (ctrl.push && pos == ctrl.fill_old) ? '0 : val_reg;
        ext  = (ctrl.tag_en && pos >= ctrl.tag_lo) ? ctrl.tag_val : base;
        val_next = ctrl.shift ? next_ext : ext;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[design/ccm_matcher.sv]
module ccm_matcher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ccm_pkg::match_req_t           req,
    input  logic [ccm_pkg::IDX_W-1:0]     eff_len,
    input  logic [ccm_pkg::CP_W-1:0]      codepoint,
    input  logic [4:0]                    pattern_index,
    output ccm_pkg::match_resp_t          resp
);

    logic [ccm_pkg::CP_W-1:0]  store_reg [ccm_pkg::PATTERN_MAX];
    logic [ccm_pkg::IDX_W-1:0] match_index_reg;
    logic [ccm_pkg::IDX_W-1:0] match_index_next;
    logic [ccm_pkg::TAG_W-1:0] count_reg;
    logic [ccm_pkg::TAG_W-1:0] count_next;
    logic [ccm_pkg::IDX_W-1:0] idx_eff;
    logic [ccm_pkg::IDX_W-1:0] idx_inc;
    logic [ccm_pkg::TAG_W-1:0] count_inc;
    logic                      hit;
    logic                      full;

    always_ff @(posedge clk)
    begin
        if (req.load && int'(pattern_index) < ccm_pkg::PATTERN_MAX)
        begin
            store_reg[pattern_index[ccm_pkg::ADDR_W-1:0]] <= codepoint;
        end
    end

    always_comb
    begin
        idx_eff   = (match_index_reg >= eff_len) ? '0 : match_index_reg;
        hit       = ccm_pkg::fold_case(codepoint)
                    == ccm_pkg::fold_case(store_reg[idx_eff[ccm_pkg::ADDR_W-1:0]]);
        idx_inc   = idx_eff + 1'b1;
        full      = (eff_len != '0) && hit && (idx_inc == eff_len);
        count_inc = (count_reg == ccm_pkg::TAG_MAX) ? count_reg : count_reg + 1'b1;

        match_index_next = match_index_reg;
        if (req.clear_index || (req.cell_in && eff_len == '0))
            match_index_next = '0;
        else if (req.cell_in)
            match_index_next = (hit && !full) ? idx_inc : '0;

        count_next = count_reg;
        if (req.clear_count)
            count_next = '0;
        else if (req.cell_in && full)
            count_next = count_inc;

        resp.full_match = req.cell_in && full;
        resp.tag_value  = count_inc;
        resp.count      = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_index_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            match_index_reg <= match_index_next;
            count_reg       <= count_next;
        end
    end

endmodule

[design/caseless_text_match_marker_core.sv]
// caseless text match marker
// cfg channel (cfg_valid/cfg_ready/pattern_length) sets the pattern length; ready is
// always high, and a write also restarts the match. write it only while idle.
// in channel (in_valid/in_ready) takes one item per transaction: kind 0 loads a
// pattern entry, kind 1 is a page cell, kind 2 ends a line, kind 3 ends a page.
// out channel (out_valid/out_ready) returns one result per transaction: a cell tag
// in stream order or the page total; last marks the final result of an item.
// a page cell is taken every cycle in steady state while out_ready is high; once the
// window holds length-1 cells, each cell releases the oldest tag, which appears
// at the output register in the cycle after the cell is accepted.
// end of line and end of page drain the window one tag per cycle from the output
// register while out_ready is high, so they hold in_ready low until the window is
// empty, and for the page total as well when the window was not empty; a length
// shrink drains the excess the same way.
// a stalled out_ready holds the output register and in_ready drops until it is
// taken; nothing is lost. reset clears the length, match index, count and
// window fill; pattern entries are undefined until loaded.
module caseless_text_match_marker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ccm_pkg::LEN_W-1:0]     pattern_length,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [ccm_pkg::CP_W-1:0]      codepoint,
    input  logic [4:0]                    pattern_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [ccm_pkg::TAG_W-1:0]     tag,
    output logic                          last
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_TOTAL = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [ccm_pkg::LEN_W-1:0]    len_reg;
    logic [ccm_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [ccm_pkg::FILL_W-1:0]   target_reg, target_next;
    logic                         total_pend_reg, total_pend_next;
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    logic [ccm_pkg::TAG_W-1:0]    out_tag_reg;
    logic                         out_last_reg;

    logic [ccm_pkg::IDX_W-1:0]    eff_len;
    logic [ccm_pkg::IDX_W-1:0]    keep;
    logic [ccm_pkg::IDX_W-1:0]    newfill;
    logic [ccm_pkg::IDX_W-1:0]    fill_w;
    logic                         slot_free;
    logic                         acc;
    logic                         cfg_acc;
    logic                         cell_go;
    logic                         flush_go;
    logic                         page_go;
    logic                         cell_pop;
    logic                         cell_multi;
    logic                         pop;
    logic                         emit;
    logic                         emit_kind;
    logic [ccm_pkg::TAG_W-1:0]    emit_tag;
    logic                         emit_last;
    logic                         count_clear;

    ccm_pkg::cell_ctrl_t          ctrl;
    ccm_pkg::match_req_t          mreq;
    ccm_pkg::match_resp_t         mresp;
    logic [ccm_pkg::TAG_W-1:0]    ext [ccm_pkg::WIN_D+1];

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_RUN) && slot_free;
    assign acc       = in_valid && in_ready;
    assign cell_go   = acc && (kind == ccm_pkg::KIND_CELL);
    assign page_go   = acc && (kind == ccm_pkg::KIND_PAGE);
    assign flush_go  = acc && ((kind == ccm_pkg::KIND_EOL) || (kind == ccm_pkg::KIND_PAGE));

    always_comb
    begin
        eff_len = (len_reg > ccm_pkg::LEN_W'(ccm_pkg::PATTERN_MAX))
                  ? ccm_pkg::IDX_W'(ccm_pkg::PATTERN_MAX)
                  : ccm_pkg::IDX_W'(len_reg);
        keep    = (eff_len == '0) ? '0 : eff_len - 1'b1;
        fill_w  = ccm_pkg::IDX_W'(fill_reg);
        newfill = fill_w + 1'b1;
        cell_pop   = newfill > keep;
        cell_multi = newfill > keep + 1'b1;
    end

    always_comb
    begin
        mreq.load        = acc && (kind == ccm_pkg::KIND_LOAD);
        mreq.cell_in     = cell_go;
        mreq.clear_index = flush_go || cfg_acc;
        mreq.clear_count = count_clear;
    end

    ccm_matcher u_matcher (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (mreq),
        .eff_len       (eff_len),
        .codepoint     (codepoint),
        .pattern_index (pattern_index),
        .resp          (mresp)
    );

    always_comb
    begin
        ctrl.push     = cell_go;
        ctrl.fill_old = fill_w;
        ctrl.tag_en   = mresp.full_match;
        ctrl.tag_lo   = (newfill > eff_len) ? newfill - eff_len : '0;
        ctrl.tag_val  = mresp.tag_value;
        ctrl.shift    = pop;
    end

    // virtual slot past the last cell: only a freshly pushed cell can sit there
    assign ext[ccm_pkg::WIN_D] = mresp.full_match ? mresp.tag_value : '0;

    for (genvar p = 0; p < ccm_pkg::WIN_D; p++)
    begin : g_win
        ccm_cell u_cell (
            .clk      (clk),
            .pos      (ccm_pkg::IDX_W'(p)),
            .ctrl     (ctrl),
            .next_ext (ext[p+1]),
            .ext      (ext[p])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        target_next     = target_reg;
        total_pend_next = total_pend_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        emit_kind       = ccm_pkg::RES_TAG;
        emit_tag        = ext[0];
        emit_last       = 1'b0;
        count_clear     = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (cell_go)
                begin
                    fill_next = cell_pop ? ccm_pkg::FILL_W'(newfill - 1'b1)
                                         : ccm_pkg::FILL_W'(newfill);
                    if (cell_pop)
                    begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        emit_last = !cell_multi;
                    end
                    if (cell_multi)
                    begin
                        state_next      = ST_DRAIN;
                        target_next     = keep[ccm_pkg::FILL_W-1:0];
                        total_pend_next = 1'b0;
                    end
                end
                else if (flush_go)
                begin
                    target_next     = '0;
                    total_pend_next = page_go;
                    if (fill_reg != '0)
                    begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        fill_next = fill_reg - 1'b1;
                        if (fill_reg == ccm_pkg::FILL_W'(1))
                        begin
                            emit_last  = !page_go;
                            state_next = page_go ? ST_TOTAL : ST_RUN;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else if (page_go)
                    begin
                        emit        = 1'b1;
                        emit_kind   = ccm_pkg::RES_TOTAL;
                        emit_tag    = mresp.count;
                        emit_last   = 1'b1;
                        count_clear = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    pop       = 1'b1;
                    emit      = 1'b1;
                    fill_next = fill_reg - 1'b1;
                    if (fill_reg - 1'b1 == target_reg)
                    begin
                        emit_last  = !total_pend_reg;
                        state_next = total_pend_reg ? ST_TOTAL : ST_RUN;
                    end
                end
            end
            ST_TOTAL:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = ccm_pkg::RES_TOTAL;
                    emit_tag    = mresp.count;
                    emit_last   = 1'b1;
                    count_clear = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            len_reg        <= '0;
            fill_reg       <= '0;
            target_reg     <= '0;
            total_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            target_reg     <= target_next;
            total_pend_reg <= total_pend_next;
            if (cfg_acc)
                len_reg <= pattern_length;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_tag_reg  <= emit_tag;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign tag         = out_tag_reg;
    assign last        = out_last_reg;

    a_drain_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> fill_reg > target_reg)
        else $error("drain state with nothing left above target");

    a_total_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == ccm_pkg::RES_TOTAL |-> out_last_reg)
        else $error("page total not flagged last");

    a_total_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TOTAL && slot_free |=> mresp.count == '0)
        else $error("count not cleared after page total");

    a_page_waits_drain: assert property (@(posedge clk) disable iff (!rst_n)
        page_go && fill_reg != '0 |=> state_reg != ST_RUN)
        else $error("page end returned to run before total");

endmodule

[verif/caseless_text_match_marker_core_tb.sv]
module caseless_text_match_marker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccm_pkg::*;

    localparam int RUN_LIMIT    = 2_000_000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 210;
    localparam int NOTE_LIMIT   = 30;

    typedef struct packed {
        res_kind_t        rk;
        logic [TAG_W-1:0] tg;
        logic             lst;
    } marker_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     pattern_length;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [CP_W-1:0]      codepoint;
    logic [4:0]           pattern_index;
    logic                 out_valid;
    logic                 out_ready;
    logic                 result_kind;
    logic [TAG_W-1:0]     tag;
    logic                 last;

    // shadow of the block
    logic [CP_W-1:0]      pat_mem [PATTERN_MAX];
    logic [LEN_W-1:0]     cur_len = '0;
    int                   match_pos = 0;
    logic [TAG_W-1:0]     occ_count = '0;
    logic [TAG_W-1:0]     held_tags [$];
    marker_result_t       due_results [$];

    // stimulus side copy of the loaded pattern
    logic [CP_W-1:0]      phrase [PATTERN_MAX];

    int  n_err = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  length_writes = 0;
    int  cycle_cnt = 0;
    int  stall_left = 0;
    bit  pace_on = 1'b1;

    caseless_text_match_marker_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("run stopped after %0d cycles with %0d results pending",
                 cycle_cnt, due_results.size());
        $display("caseless_text_match_marker_core regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!pace_on)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // receiver stalls
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (pace_on && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap() + 1;
            end
        end
    end

    function automatic logic [CP_W-1:0] lower_ascii(logic [CP_W-1:0] c);
        if (c >= 'h41 && c <= 'h5A)
            return c + CP_W'('h20);
        return c;
    endfunction

    function automatic int eff_len(logic [LEN_W-1:0] v);
        return (v > PATTERN_MAX) ? PATTERN_MAX : int'(v);
    endfunction

    function automatic int release_tags(int keep);
        int n;
        n = 0;
        while (held_tags.size() > keep)
        begin
            due_results.push_back('{RES_TAG, held_tags.pop_front(), 1'b0});
            n++;
        end
        return n;
    endfunction

    function automatic void track_marker_item(kind_t k, logic [CP_W-1:0] cp,
                                              logic [4:0] pi);
        int len;
        int idx;
        int span;
        int n_new;
        int j;
        n_new = 0;
        len = eff_len(cur_len);
        case (k)
            KIND_LOAD:
                pat_mem[pi] = cp;
            KIND_CELL:
            begin
                held_tags.push_back('0);
                if (len == 0)
                    match_pos = 0;
                else
                begin
                    idx = (match_pos >= len) ? 0 : match_pos;
                    // a miss drops back to zero without retrying this cell
                    if (lower_ascii(cp) == lower_ascii(pat_mem[idx]))
                        idx++;
                    else
                        idx = 0;
                    if (idx == len)
                    begin
                        if (occ_count != TAG_MAX)
                            occ_count++;
                        span = (len < held_tags.size()) ? len : held_tags.size();
                        for (j = 0; j < span; j++)
                            held_tags[held_tags.size() - 1 - j] = occ_count;
                        idx = 0;
                    end
                    match_pos = idx;
                end
                n_new = release_tags((len == 0) ? 0 : len - 1);
            end
            KIND_EOL:
            begin
                n_new = release_tags(0);
                match_pos = 0;
            end
            default:
            begin
                n_new = release_tags(0);
                due_results.push_back('{RES_TOTAL, occ_count, 1'b0});
                n_new++;
                match_pos = 0;
                occ_count = '0;
            end
        endcase
        if (n_new > 0)
            due_results[due_results.size() - 1].lst = 1'b1;
    endfunction

    task automatic report(string what);
        n_err++;
        if (n_err <= NOTE_LIMIT)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic take_marker_result();
        marker_result_t want;
        results_seen++;
        if (due_results.size() == 0)
        begin
            report($sformatf("result %0d with nothing pending: kind %0d tag %0d last %0d",
                             results_seen, result_kind, tag, last));
            return;
        end
        want = due_results.pop_front();
        if (result_kind !== want.rk)
            report($sformatf("result %0d kind %0d, want %0d",
                             results_seen, result_kind, want.rk));
        if (tag !== want.tg)
            report($sformatf("result %0d tag %0d, want %0d", results_seen, tag, want.tg));
        if (last !== want.lst)
            report($sformatf("result %0d last %0d, want %0d",
                             results_seen, last, want.lst));
    endtask

    // input prediction runs before the output check of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cur_len = pattern_length;
                match_pos = 0;
            end
            if (in_valid && in_ready)
                track_marker_item(kind_t'(kind), codepoint, pattern_index);
            if (out_valid && out_ready)
                take_marker_result();
        end
    end

    task automatic send_item(kind_t k, logic [CP_W-1:0] cp, logic [4:0] idx);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        codepoint     <= cp;
        pattern_index <= idx;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic load_entry(int idx, logic [CP_W-1:0] cp);
        phrase[idx] = cp;
        send_item(KIND_LOAD, cp, 5'(idx));
    endtask

    task automatic send_cell(logic [CP_W-1:0] cp);
        send_item(KIND_CELL, cp, 5'($urandom));
    endtask

    task automatic end_line();
        send_item(KIND_EOL, CP_W'($urandom), 5'($urandom));
    endtask

    task automatic end_page();
        send_item(KIND_PAGE, CP_W'($urandom), 5'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid      <= 1'b1;
        pattern_length <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        length_writes++;
    endtask

    function automatic logic [CP_W-1:0] vary_case(logic [CP_W-1:0] c);
        if (((c >= 'h41 && c <= 'h5A) || (c >= 'h61 && c <= 'h7A)) && $urandom_range(0, 1))
            return c ^ CP_W'('h20);
        return c;
    endfunction

    function automatic logic [CP_W-1:0] pick_symbol(int style);
        case (style)
            0: return vary_case($urandom_range(0, 1) ? CP_W'('h61) : CP_W'('h62));
            1: return vary_case(CP_W'('h61 + $urandom_range(0, 25)));
            2: return CP_W'($urandom_range(0, 'h1FFFFF));
            default:
                case ($urandom_range(0, 5))
                    0: return 'h40;
                    1: return 'h5B;
                    2: return 'h60;
                    3: return 'h7B;
                    4: return 'h5A;
                    default: return 'h7A;
                endcase
        endcase
    endfunction

    function automatic logic [CP_W-1:0] pick_noise(int style, int len);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && len > 0)
            return vary_case(phrase[$urandom_range(0, len - 1)]);
        if (r < 7)
            return pick_symbol(style);
        if (r < 9)
            return pick_symbol($urandom_range(0, 3));
        return CP_W'($urandom_range(0, 'h1FFFFF));
    endfunction

    task automatic test_store_fill();
        int i;
        for (i = 0; i < PATTERN_MAX; i++)
            load_entry(i, (i == 0) ? CP_W'(0) :
                          (i == PATTERN_MAX - 1) ? CP_W'('h1FFFFF) : CP_W'($urandom));
    endtask

    task automatic test_zero_length();
        write_length(0);
        send_cell('h1FFFFF);
        send_cell('h41);
        send_cell(0);
        // window is empty here, so the line end gives no result and the page end only the total
        end_line();
        end_page();
    endtask

    task automatic test_case_fold();
        write_length(3);
        load_entry(0, 'h41);
        load_entry(1, 'h62);
        load_entry(2, 'h5B);
        send_cell('h61);
        send_cell('h42);
        send_cell('h5B);
        // brace is not a folded bracket, and latin letters above ascii stay put
        send_cell('h41);
        send_cell('h62);
        send_cell('h7B);
        send_cell('hC0);
        send_cell('h41);
        send_cell('h42);
        send_cell('h5B);
        end_line();
        end_page();
    endtask

    task automatic test_miss_rule();
        load_entry(0, 'h61);
        load_entry(1, 'h61);
        load_entry(2, 'h62);
        send_cell('h61);
        send_cell('h61);
        send_cell('h61);
        send_cell('h62);
        send_cell('h61);
        send_cell('h41);
        send_cell('h62);
        // line end breaks a partial match
        send_cell('h61);
        send_cell('h61);
        end_line();
        send_cell('h62);
        end_page();
    endtask

    task automatic test_length_write();
        int i;
        write_length(6);
        for (i = 0; i < 8; i++)
            send_cell('h78);
        // window holds five cells across the shrink
        write_length(2);
        send_cell('h61);
        send_cell('h41);
        end_line();
        end_page();
    endtask

    task automatic test_full_length();
        int i;
        write_length(63);
        for (i = 0; i < PATTERN_MAX; i++)
            send_cell(vary_case(phrase[i]));
        end_line();
        end_page();
    endtask

    task automatic random_page();
        logic [LEN_W-1:0] v;
        int len;
        int style;
        int target;
        int made;
        int r;
        int n;
        int i;
        case ($urandom_range(0, 11))
            0: v = 1;
            1: v = 2;
            2: v = 3;
            3: v = 4;
            4: v = 5;
            5: v = 8;
            6: v = 32;
            7: v = 33;
            8: v = 0;
            default: v = LEN_W'($urandom_range(1, 63));
        endcase
        write_length(v);
        pace_on = ($urandom_range(0, 3) != 0);
        len = eff_len(v);
        style = $urandom_range(0, 3);
        for (i = 0; i < len; i++)
            load_entry(i, pick_symbol(style));
        target = 25 + 2 * len;
        made = 0;
        while (made < target)
        begin
            r = $urandom_range(0, 99);
            if (len > 0 && r < 45)
            begin
                for (i = 0; i < len; i++)
                    send_cell(vary_case(phrase[i]));
                made += len;
            end
            else if (len > 1 && r < 60)
            begin
                n = $urandom_range(1, len - 1);
                for (i = 0; i < n; i++)
                    send_cell(vary_case(phrase[i]));
                made += n;
            end
            else if (r < 82)
            begin
                send_cell(pick_noise(style, len));
                made++;
            end
            else if (r < 90)
            begin
                load_entry($urandom_range(0, PATTERN_MAX - 1), pick_symbol(style));
                made++;
            end
            else
            begin
                end_line();
                made++;
            end
        end
        end_page();
    endtask

    task automatic test_random_stream();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            random_page();
        pace_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        pattern_length = '0;
        in_valid       = 1'b0;
        kind           = KIND_LOAD;
        codepoint      = '0;
        pattern_index  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_store_fill();
        test_zero_length();
        test_case_fold();
        test_miss_rule();
        test_length_write();
        test_full_length();
        test_random_stream();
        wait_idle();

        $display("covered %0d input transactions, %0d results checked, %0d length writes",
                 items_sent, results_seen, length_writes);
        $display("case folding, the miss rule, zero and clamped lengths, shrink with held cells"
                 , " and random pages");
        if (n_err == 0)
            $display("caseless_text_match_marker_core regression: pass");
        else
            $display("caseless_text_match_marker_core regression: fail");
        $finish;
    end

endmodule
